FILE: sv/switch_command_pulse_queue_core_defines.svh
// assertion macros for the switch command pulse queue
`ifndef SWITCH_COMMAND_PULSE_QUEUE_CORE_DEFINES_SVH
`define SWITCH_COMMAND_PULSE_QUEUE_CORE_DEFINES_SVH

// same-cycle implication, clocked on clk_i, off during reset
`define SCPQ_ASSERT_IMP(lbl, ante, cons) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error("scpq assertion failed");

// next-cycle implication, clocked on clk_i, off during reset
`define SCPQ_ASSERT_NXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error("scpq assertion failed");

`endif

FILE: sv/scpq_pkg.sv
// shared types and constants of the switch command pulse queue
package scpq_pkg;

  localparam int unsigned QueueDepthDef = 64;
  localparam int unsigned TimeW         = 16;
  localparam int unsigned AddrW         = 15;
  localparam int unsigned CountW        = 6;
  localparam int unsigned PhaseW        = 2;
  localparam int unsigned OpW           = 2;
  localparam int unsigned ApbAddrW      = 3;
  localparam int unsigned ApbDataW      = 32;

  localparam logic [TimeW-1:0] TimeResetVal = 16'd125;

  localparam logic [PhaseW-1:0] PhIdle = 2'd0;
  localparam logic [PhaseW-1:0] PhOn   = 2'd1;
  localparam logic [PhaseW-1:0] PhGap  = 2'd2;
  localparam logic [PhaseW-1:0] PhWait = 2'd3;

  localparam logic RegOnTime  = 1'b0;
  localparam logic RegGapTime = 1'b1;

  typedef enum logic [OpW-1:0] {
    OP_ADD  = 2'd0,
    OP_TICK = 2'd1,
    OP_TX   = 2'd2,
    OP_NOP  = 2'd3
  } op_e;

  typedef struct packed {
    logic              in_ready;
    logic              load;
    logic              push;
    logic              pop;
    logic              inc_ticks;
    logic              clr_ticks;
    logic              send;
    logic              send_on;
    logic              dropped;
    logic [PhaseW-1:0] phase;
  } cmd_t;

  typedef struct packed {
    logic [OpW-1:0] op;
    logic           tx_success;
    logic           empty;
    logic           full;
    logic           on_done;
    logic           gap_done;
    logic           out_free;
  } sts_t;

endpackage

FILE: sv/scpq_if.sv
// transaction channels of the switch command pulse queue
interface scpq_in_if;
  logic                           valid;
  logic                           ready;
  logic [scpq_pkg::OpW-1:0]       op;
  logic [scpq_pkg::AddrW-1:0]     address;
  logic                           direction;
  logic                           tx_success;

  modport source (output valid, op, address, direction, tx_success, input ready);
  modport sink (input valid, op, address, direction, tx_success, output ready);
endinterface

interface scpq_out_if;
  logic                            valid;
  logic                            ready;
  logic                            send_valid;
  logic [scpq_pkg::AddrW-1:0]      send_address;
  logic                            send_direction;
  logic                            send_on;
  logic                            add_dropped;
  logic [scpq_pkg::CountW-1:0]     pending_count;
  logic [scpq_pkg::PhaseW-1:0]     phase;

  modport source (output valid, send_valid, send_address, send_direction, send_on,
                  add_dropped, pending_count, phase, input ready);
  modport sink (input valid, send_valid, send_address, send_direction, send_on,
                add_dropped, pending_count, phase, output ready);
endinterface

FILE: sv/scpq_ctrl.sv
// controller: transaction handshake and pulse sequencer state machine
module scpq_ctrl (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  logic            in_valid_i,
  input  scpq_pkg::sts_t  sts_i,
  output scpq_pkg::cmd_t  cmd_o
);

  typedef enum logic {
    CS_ACCEPT,
    CS_EXEC
  } ctl_e;

  typedef enum logic [scpq_pkg::PhaseW-1:0] {
    SEQ_IDLE = scpq_pkg::PhIdle,
    SEQ_ON   = scpq_pkg::PhOn,
    SEQ_GAP  = scpq_pkg::PhGap,
    SEQ_WAIT = scpq_pkg::PhWait
  } seq_e;

  ctl_e ctl_q, ctl_d;
  seq_e seq_q, seq_d;
  seq_e await_q, await_d;

  always_comb begin
    cmd_o    = '0;
    ctl_d    = ctl_q;
    seq_d    = seq_q;
    await_d  = await_q;
    cmd_o.in_ready = (ctl_q == CS_ACCEPT) && sts_i.out_free;
    case (ctl_q)
      CS_ACCEPT: begin
        if (in_valid_i && cmd_o.in_ready) begin
          ctl_d = CS_EXEC;
        end
      end
      CS_EXEC: begin
        ctl_d      = CS_ACCEPT;
        cmd_o.load = 1'b1;
        case (scpq_pkg::op_e'(sts_i.op))
          scpq_pkg::OP_ADD: begin
            cmd_o.push    = !sts_i.full;
            cmd_o.dropped = sts_i.full;
          end
          scpq_pkg::OP_TICK: begin
            cmd_o.inc_ticks = 1'b1;
            case (seq_q)
              SEQ_IDLE: begin
                if (!sts_i.empty) begin
                  seq_d         = SEQ_WAIT;
                  await_d       = SEQ_ON;
                  cmd_o.send    = 1'b1;
                  cmd_o.send_on = 1'b1;
                end
              end
              SEQ_ON: begin
                if (sts_i.on_done) begin
                  seq_d      = SEQ_WAIT;
                  await_d    = SEQ_GAP;
                  cmd_o.send = 1'b1;
                end
              end
              SEQ_GAP: begin
                if (sts_i.gap_done) begin
                  seq_d     = SEQ_IDLE;
                  cmd_o.pop = 1'b1;
                end
              end
              default: ;
            endcase
          end
          scpq_pkg::OP_TX: begin
            if (seq_q == SEQ_WAIT) begin
              if (sts_i.tx_success) begin
                seq_d           = await_q;
                cmd_o.clr_ticks = 1'b1;
              end else begin
                seq_d = SEQ_IDLE;
              end
            end
          end
          default: ;
        endcase
      end
      default: ctl_d = CS_ACCEPT;
    endcase
    cmd_o.phase = seq_d;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      ctl_q   <= CS_ACCEPT;
      seq_q   <= SEQ_IDLE;
      await_q <= SEQ_IDLE;
    end else begin
      ctl_q   <= ctl_d;
      seq_q   <= seq_d;
      await_q <= await_d;
    end
  end

endmodule

FILE: sv/scpq_dp.sv
// datapath: command store, pointers, tick counter, settings and result register
module scpq_dp #(
  parameter int unsigned QUEUE_DEPTH = scpq_pkg::QueueDepthDef
) (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  input  logic                              in_valid_i,
  input  logic [scpq_pkg::OpW-1:0]          in_op_i,
  input  logic [scpq_pkg::AddrW-1:0]        in_address_i,
  input  logic                              in_direction_i,
  input  logic                              in_tx_success_i,
  input  scpq_pkg::cmd_t                    cmd_i,
  output scpq_pkg::sts_t                    sts_o,
  input  logic                              out_ready_i,
  output logic                              out_valid_o,
  output logic                              send_valid_o,
  output logic [scpq_pkg::AddrW-1:0]        send_address_o,
  output logic                              send_direction_o,
  output logic                              send_on_o,
  output logic                              add_dropped_o,
  output logic [scpq_pkg::CountW-1:0]       pending_count_o,
  output logic [scpq_pkg::PhaseW-1:0]       phase_o,
  input  logic                              psel,
  input  logic                              penable,
  input  logic                              pwrite,
  input  logic [scpq_pkg::ApbAddrW-1:0]     paddr,
  input  logic [scpq_pkg::ApbDataW-1:0]     pwdata,
  output logic [scpq_pkg::ApbDataW-1:0]     prdata,
  output logic                              pready
);

  localparam int unsigned PtrW     = $clog2(QUEUE_DEPTH);
  localparam int unsigned EntryW   = scpq_pkg::AddrW + 1;
  localparam int unsigned CountMax = (2 ** scpq_pkg::CountW) - 1;
  localparam logic [PtrW-1:0] PtrLast = PtrW'(QUEUE_DEPTH - 1);

  logic [EntryW-1:0] mem [QUEUE_DEPTH];
  logic [EntryW-1:0] head_q;

  logic [PtrW-1:0] rd_ptr_q, rd_ptr_d;
  logic [PtrW-1:0] wr_ptr_q, wr_ptr_d;
  logic [PtrW-1:0] cnt_q, cnt_d;
  logic [scpq_pkg::TimeW-1:0] ticks_q, ticks_d, ticks_inc;
  logic [scpq_pkg::TimeW-1:0] on_time_q, gap_time_q;

  logic [scpq_pkg::OpW-1:0]   op_q;
  logic [scpq_pkg::AddrW-1:0] addr_q;
  logic                       dir_q;
  logic                       ok_q;

  logic                       out_valid_q;
  logic                       cfg_wr;
  logic [scpq_pkg::CountW-1:0] pend;

  // item capture
  always_ff @(posedge clk_i) begin
    if (in_valid_i && cmd_i.in_ready) begin
      op_q   <= in_op_i;
      addr_q <= in_address_i;
      dir_q  <= in_direction_i;
      ok_q   <= in_tx_success_i;
    end
  end

  // command store
  always_ff @(posedge clk_i) begin
    if (cmd_i.push) begin
      mem[wr_ptr_q] <= {dir_q, addr_q};
    end
    head_q <= mem[rd_ptr_q];
  end

  assign ticks_inc = (ticks_q != '1) ? ticks_q + 1'b1 : ticks_q;

  always_comb begin
    rd_ptr_d = rd_ptr_q;
    wr_ptr_d = wr_ptr_q;
    cnt_d    = cnt_q;
    ticks_d  = ticks_q;
    if (cmd_i.push) begin
      wr_ptr_d = (wr_ptr_q == PtrLast) ? '0 : wr_ptr_q + 1'b1;
      cnt_d    = cnt_q + 1'b1;
    end
    if (cmd_i.pop) begin
      rd_ptr_d = (rd_ptr_q == PtrLast) ? '0 : rd_ptr_q + 1'b1;
      cnt_d    = cnt_q - 1'b1;
    end
    if (cmd_i.clr_ticks) begin
      ticks_d = '0;
    end else if (cmd_i.inc_ticks) begin
      ticks_d = ticks_inc;
    end
  end

  always_comb begin
    if (32'(cnt_d) > 32'(CountMax)) begin
      pend = '1;
    end else begin
      pend = scpq_pkg::CountW'(cnt_d);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      rd_ptr_q <= '0;
      wr_ptr_q <= '0;
      cnt_q    <= '0;
      ticks_q  <= '0;
    end else begin
      rd_ptr_q <= rd_ptr_d;
      wr_ptr_q <= wr_ptr_d;
      cnt_q    <= cnt_d;
      ticks_q  <= ticks_d;
    end
  end

  assign sts_o.op         = op_q;
  assign sts_o.tx_success = ok_q;
  assign sts_o.empty      = (cnt_q == '0);
  assign sts_o.full       = (cnt_q == PtrLast);
  assign sts_o.on_done    = (ticks_inc >= on_time_q);
  assign sts_o.gap_done   = (ticks_inc >= gap_time_q);
  assign sts_o.out_free   = !out_valid_q || out_ready_i;

  // result register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (cmd_i.load) begin
      out_valid_q <= 1'b1;
    end else if (out_ready_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.load) begin
      send_valid_o     <= cmd_i.send;
      send_address_o   <= cmd_i.send ? head_q[scpq_pkg::AddrW-1:0] : '0;
      send_direction_o <= cmd_i.send ? head_q[EntryW-1] : 1'b0;
      send_on_o        <= cmd_i.send_on;
      add_dropped_o    <= cmd_i.dropped;
      pending_count_o  <= pend;
      phase_o          <= cmd_i.phase;
    end
  end

  assign out_valid_o = out_valid_q;

  // settings registers
  assign cfg_wr = psel && penable && pwrite;
  assign pready = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      on_time_q  <= scpq_pkg::TimeResetVal;
      gap_time_q <= scpq_pkg::TimeResetVal;
    end else if (cfg_wr) begin
      if (paddr[2] == scpq_pkg::RegOnTime) begin
        on_time_q <= pwdata[scpq_pkg::TimeW-1:0];
      end else begin
        gap_time_q <= pwdata[scpq_pkg::TimeW-1:0];
      end
    end
  end

  always_comb begin
    if (paddr[2] == scpq_pkg::RegGapTime) begin
      prdata = scpq_pkg::ApbDataW'(gap_time_q);
    end else begin
      prdata = scpq_pkg::ApbDataW'(on_time_q);
    end
  end

endmodule

FILE: sv/switch_command_pulse_queue_core.sv
// top level of the switch command pulse queue
// result: registered at the rising edge after the one that accepts the transaction
// a new item is taken only after the controller has executed the previous one and is back in its accept state
// the next item is taken while the previous result still waits, if it leaves this cycle
// reset: pointers, tick counter and sequencer cleared, both times back to 125 ticks
// command store contents are not cleared; only written entries are ever read
module switch_command_pulse_queue_core #(
  parameter int unsigned QUEUE_DEPTH = scpq_pkg::QueueDepthDef
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  scpq_in_if.sink                       item_i,
  scpq_out_if.source                    result_o,
  input  logic                          psel,
  input  logic                          penable,
  input  logic                          pwrite,
  input  logic [scpq_pkg::ApbAddrW-1:0] paddr,
  input  logic [scpq_pkg::ApbDataW-1:0] pwdata,
  output logic [scpq_pkg::ApbDataW-1:0] prdata,
  output logic                          pready
);

  `include "switch_command_pulse_queue_core_defines.svh"

  scpq_pkg::cmd_t cmd;
  scpq_pkg::sts_t sts;

  scpq_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (item_i.valid),
    .sts_i      (sts),
    .cmd_o      (cmd)
  );

  scpq_dp #(
    .QUEUE_DEPTH (QUEUE_DEPTH)
  ) u_dp (
    .clk_i            (clk_i),
    .rst_ni           (rst_ni),
    .in_valid_i       (item_i.valid),
    .in_op_i          (item_i.op),
    .in_address_i     (item_i.address),
    .in_direction_i   (item_i.direction),
    .in_tx_success_i  (item_i.tx_success),
    .cmd_i            (cmd),
    .sts_o            (sts),
    .out_ready_i      (result_o.ready),
    .out_valid_o      (result_o.valid),
    .send_valid_o     (result_o.send_valid),
    .send_address_o   (result_o.send_address),
    .send_direction_o (result_o.send_direction),
    .send_on_o        (result_o.send_on),
    .add_dropped_o    (result_o.add_dropped),
    .pending_count_o  (result_o.pending_count),
    .phase_o          (result_o.phase),
    .psel             (psel),
    .penable          (penable),
    .pwrite           (pwrite),
    .paddr            (paddr),
    .pwdata           (pwdata),
    .prdata           (prdata),
    .pready           (pready)
  );

  assign item_i.ready = cmd.in_ready;

  `SCPQ_ASSERT_NXT(a_accept_then_exec, item_i.valid && item_i.ready, !item_i.ready)
  `SCPQ_ASSERT_IMP(a_push_not_full, cmd.push, !sts.full)
  `SCPQ_ASSERT_IMP(a_send_awaits_result, result_o.valid && result_o.send_valid, result_o.phase == scpq_pkg::PhWait)
  `SCPQ_ASSERT_NXT(a_load_shows_result, cmd.load, result_o.valid)

endmodule

FILE: bench/switch_command_pulse_queue_core_tb.sv
// self-checking bench for the switch command pulse queue: random traffic, timing changes
`timescale 1ns / 100ps

module switch_command_pulse_queue_core_tb;
  import scpq_pkg::*;

  localparam int unsigned Depth  = QueueDepthDef;
  localparam int unsigned TbPtrW = $clog2(Depth);

  typedef struct packed {
    op_e              op;
    logic [AddrW-1:0] address;
    logic             direction;
    logic             tx_success;
  } switch_cmd_t;

  typedef struct packed {
    logic              send_valid;
    logic [AddrW-1:0]  send_address;
    logic              send_direction;
    logic              send_on;
    logic              add_dropped;
    logic [CountW-1:0] pending_count;
    logic [PhaseW-1:0] phase;
  } switch_report_t;

  logic clk_i = 1'b0;
  logic rst_ni;
  logic                psel;
  logic                penable;
  logic                pwrite;
  logic [ApbAddrW-1:0] paddr;
  logic [ApbDataW-1:0] pwdata;
  logic [ApbDataW-1:0] prdata;
  logic                pready;

  scpq_in_if  item_if ();
  scpq_out_if result_if ();

  switch_command_pulse_queue_core dut (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .item_i   (item_if),
    .result_o (result_if),
    .psel     (psel),
    .penable  (penable),
    .pwrite   (pwrite),
    .paddr    (paddr),
    .pwdata   (pwdata),
    .prdata   (prdata),
    .pready   (pready)
  );

  always #5 clk_i = ~clk_i;

  // shadow of the sequencer
  logic [AddrW:0]    cmd_store [Depth];
  int unsigned       rd_ptr;
  int unsigned       wr_ptr;
  logic [PhaseW-1:0] seq_phase;
  logic [PhaseW-1:0] awaited_phase;
  logic [TimeW-1:0]  elapsed;
  logic [TimeW-1:0]  on_ticks;
  logic [TimeW-1:0]  gap_ticks;

  switch_cmd_t    cmd_backlog[$];
  switch_report_t due_reports[$];
  switch_cmd_t    next_cmd;
  switch_cmd_t    bus_cmd;
  switch_report_t want;

  int src_idle_pct;
  int dst_idle_pct;
  int errors;
  int n_reports;
  int n_sends;
  int n_drops;

  function automatic int unsigned queued_commands();
    return (wr_ptr + Depth - rd_ptr) % Depth;
  endfunction

  function automatic switch_report_t step_sequencer(switch_cmd_t c);
    switch_report_t r;
    logic [AddrW:0] head;
    int unsigned    used;
    r = '0;
    used = queued_commands();
    head = cmd_store[TbPtrW'(rd_ptr)];
    case (c.op)
      OP_ADD: begin
        if (used >= Depth - 1) begin
          r.add_dropped = 1'b1;
        end else begin
          cmd_store[TbPtrW'(wr_ptr)] = {c.direction, c.address};
          wr_ptr = (wr_ptr + 1) % Depth;
        end
      end
      OP_TICK: begin
        if (elapsed != '1) elapsed = elapsed + 1'b1;
        case (seq_phase)
          PhIdle: begin
            if (used != 0) begin
              seq_phase = PhWait;
              awaited_phase = PhOn;
              r.send_valid = 1'b1;
              r.send_on = 1'b1;
              r.send_address = head[AddrW-1:0];
              r.send_direction = head[AddrW];
            end
          end
          PhOn: begin
            if (elapsed >= on_ticks) begin
              seq_phase = PhWait;
              awaited_phase = PhGap;
              r.send_valid = 1'b1;
              r.send_address = head[AddrW-1:0];
              r.send_direction = head[AddrW];
            end
          end
          PhGap: begin
            if (elapsed >= gap_ticks) begin
              rd_ptr = (rd_ptr + 1) % Depth;
              seq_phase = PhIdle;
            end
          end
          default: ;
        endcase
      end
      OP_TX: begin
        if (seq_phase == PhWait) begin
          if (c.tx_success) begin
            elapsed = '0;
            seq_phase = awaited_phase;
          end else begin
            seq_phase = PhIdle;
          end
        end
      end
      default: ;
    endcase
    used = queued_commands();
    r.pending_count = (used > 63) ? CountW'(63) : CountW'(used);
    r.phase = seq_phase;
    return r;
  endfunction

  // stimulus side
  always @(posedge clk_i) begin
    if (rst_ni) begin
      if (item_if.valid && item_if.ready) begin
        bus_cmd.op = op_e'(item_if.op);
        bus_cmd.address = item_if.address;
        bus_cmd.direction = item_if.direction;
        bus_cmd.tx_success = item_if.tx_success;
        due_reports.push_back(step_sequencer(bus_cmd));
      end
      if (!item_if.valid || item_if.ready) begin
        if (cmd_backlog.size() != 0 && $urandom_range(99) >= src_idle_pct) begin
          next_cmd = cmd_backlog.pop_front();
          item_if.valid <= 1'b1;
          item_if.op <= next_cmd.op;
          item_if.address <= next_cmd.address;
          item_if.direction <= next_cmd.direction;
          item_if.tx_success <= next_cmd.tx_success;
        end else begin
          item_if.valid <= 1'b0;
        end
      end
    end
  end

  task automatic check_field(string name, int unsigned exp_val, int unsigned got_val);
    if (exp_val != got_val) begin
      $display("%0t %s: expected %0d, got %0d", $time, name, exp_val, got_val);
      errors++;
    end
  endtask

  // result side
  always @(posedge clk_i) begin
    if (rst_ni) begin
      if (result_if.valid && result_if.ready) begin
        if (due_reports.size() == 0) begin
          $display("%0t unexpected transaction on the result channel", $time);
          errors++;
        end else begin
          want = due_reports.pop_front();
          check_field("send_valid", 32'(want.send_valid), 32'(result_if.send_valid));
          check_field("send_address", 32'(want.send_address),
                      32'(result_if.send_address));
          check_field("send_direction", 32'(want.send_direction),
                      32'(result_if.send_direction));
          check_field("send_on", 32'(want.send_on), 32'(result_if.send_on));
          check_field("add_dropped", 32'(want.add_dropped), 32'(result_if.add_dropped));
          check_field("pending_count", 32'(want.pending_count),
                      32'(result_if.pending_count));
          check_field("phase", 32'(want.phase), 32'(result_if.phase));
          n_reports++;
          n_sends += int'(want.send_valid);
          n_drops += int'(want.add_dropped);
        end
      end
      result_if.ready <= ($urandom_range(99) >= dst_idle_pct);
    end
  end

  task automatic queue_cmd(op_e op, logic [AddrW-1:0] adr, logic dir, logic ok);
    switch_cmd_t c;
    c.op = op;
    c.address = adr;
    c.direction = dir;
    c.tx_success = ok;
    cmd_backlog.push_back(c);
  endtask

  task automatic queue_any(op_e op, logic ok);
    queue_cmd(op, AddrW'($urandom_range(0, 32767)), 1'($urandom_range(1)), ok);
  endtask

  task automatic queue_traffic(int n, int add_w);
    int made;
    int pick;
    int k;
    made = 0;
    while (made < n) begin
      pick = $urandom_range(99);
      if (pick < add_w) begin
        k = $urandom_range(1, 4);
        repeat (k) queue_any(OP_ADD, 1'($urandom_range(1)));
        made += k;
      end else if (pick < add_w + 40) begin
        // on request, on time, off request, gap
        queue_any(OP_TICK, 1'($urandom_range(1)));
        queue_any(OP_TX, $urandom_range(99) < 85);
        k = $urandom_range(0, 7);
        repeat (k) queue_any(OP_TICK, 1'($urandom_range(1)));
        made += k + 2;
        queue_any(OP_TICK, 1'($urandom_range(1)));
        queue_any(OP_TX, $urandom_range(99) < 85);
        k = $urandom_range(0, 7);
        repeat (k) queue_any(OP_TICK, 1'($urandom_range(1)));
        made += k + 2;
      end else if (pick < add_w + 60) begin
        k = $urandom_range(1, 5);
        repeat (k) queue_any(OP_TICK, 1'($urandom_range(1)));
        made += k;
      end else if (pick < add_w + 80) begin
        queue_any(OP_TX, 1'($urandom_range(1)));
        made++;
      end else begin
        queue_any(op_e'($urandom_range(3)), 1'($urandom_range(1)));
        made++;
      end
    end
  endtask

  task automatic write_timing(logic reg_sel, logic [TimeW-1:0] ticks);
    @(posedge clk_i);
    psel <= 1'b1;
    penable <= 1'b0;
    pwrite <= 1'b1;
    paddr <= {reg_sel, 2'b00};
    pwdata <= ApbDataW'(ticks);
    @(posedge clk_i);
    penable <= 1'b1;
    @(posedge clk_i);
    while (!pready) @(posedge clk_i);
    psel <= 1'b0;
    penable <= 1'b0;
    pwrite <= 1'b0;
    if (reg_sel == RegOnTime) on_ticks = ticks;
    else gap_ticks = ticks;
  endtask

  task automatic settle();
    @(negedge clk_i);
    while (cmd_backlog.size() != 0 || item_if.valid || due_reports.size() != 0)
      @(negedge clk_i);
    repeat (3) @(negedge clk_i);
  endtask

  task automatic run_phase(int on_t, int gap_t, int src_pct, int dst_pct, int n, int add_w);
    settle();
    write_timing(RegOnTime, TimeW'(on_t));
    write_timing(RegGapTime, TimeW'(gap_t));
    src_idle_pct = src_pct;
    dst_idle_pct = dst_pct;
    queue_traffic(n, add_w);
  endtask

  initial begin
    item_if.valid = 1'b0;
    item_if.op = OP_NOP;
    item_if.address = '0;
    item_if.direction = 1'b0;
    item_if.tx_success = 1'b0;
    result_if.ready = 1'b0;
    psel = 1'b0;
    penable = 1'b0;
    pwrite = 1'b0;
    paddr = '0;
    pwdata = '0;
    rst_ni = 1'b0;
    cmd_store = '{default: '0};
    rd_ptr = 0;
    wr_ptr = 0;
    seq_phase = PhIdle;
    awaited_phase = PhIdle;
    elapsed = '0;
    on_ticks = TimeResetVal;
    gap_ticks = TimeResetVal;
    src_idle_pct = 25;
    dst_idle_pct = 79;
    errors = 0;
    n_reports = 0;
    n_sends = 0;
    n_drops = 0;
    repeat (9) @(posedge clk_i);
    rst_ni <= 1'b1;

    write_timing(RegOnTime, TimeW'(1));
    write_timing(RegGapTime, TimeW'(1));
    // idle and empty, then a full service with failed on and off sends
    queue_cmd(OP_TX, '0, 1'b0, 1'b1);
    queue_cmd(OP_TICK, '1, 1'b1, 1'b0);
    queue_cmd(OP_ADD, '0, 1'b0, 1'b0);
    queue_cmd(OP_ADD, '1, 1'b1, 1'b1);
    queue_cmd(OP_NOP, '1, 1'b1, 1'b1);
    queue_cmd(OP_TICK, '0, 1'b0, 1'b0);
    queue_cmd(OP_TICK, '0, 1'b0, 1'b0);
    queue_cmd(OP_TX, '0, 1'b0, 1'b0);
    queue_cmd(OP_TICK, '0, 1'b0, 1'b0);
    queue_cmd(OP_TX, '0, 1'b0, 1'b1);
    queue_cmd(OP_TICK, '0, 1'b0, 1'b0);
    queue_cmd(OP_TX, '0, 1'b0, 1'b0);
    queue_cmd(OP_TICK, '0, 1'b0, 1'b0);
    queue_cmd(OP_TX, '0, 1'b0, 1'b1);
    queue_cmd(OP_TICK, '0, 1'b0, 1'b0);
    queue_cmd(OP_TX, '1, 1'b1, 1'b1);
    queue_cmd(OP_TX, '1, 1'b1, 1'b1);
    queue_cmd(OP_TICK, '1, 1'b1, 1'b1);
    queue_cmd(OP_TICK, '1, 1'b1, 1'b1);
    queue_cmd(OP_TX, '1, 1'b1, 1'b1);
    queue_cmd(OP_TICK, '1, 1'b1, 1'b1);
    queue_cmd(OP_TX, '1, 1'b1, 1'b1);
    queue_cmd(OP_TICK, '1, 1'b1, 1'b1);

    run_phase(3, 2, 25, 79, 150, 20);
    // long gap keeps the head in service so the queue fills
    run_phase(1, 65535, 25, 79, 100, 70);
    run_phase(65535, 1, 79, 25, 80, 20);
    run_phase($urandom_range(1, 6), $urandom_range(1, 6), 79, 25, 120, 20);
    run_phase(2, 1, 0, 0, 100, 25);
    settle();

    $display("covered %0d transactions, %0d switch requests and %0d refused adds",
             n_reports, n_sends, n_drops);
    $display("timings from 1 to 65535 ticks under three pacing modes of both channels");
    if (errors == 0) begin
      $display("Test completed successfully");
    end else begin
      $display("Test completed with failures");
    end
    $finish;
  end

  initial begin
    #(5_000_000);
    $display("timeout");
    $display("Test completed with failures");
    $finish;
  end

endmodule
